[rtl/l2tk_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// l2tk_pkg: shared types and constants of the k-nearest search block
// Field widths, opcodes, register indexes and stage structs.
// ----------------------------------------------------------------------------
package l2tk_pkg;

    localparam int ELEM_W      = 16;
    localparam int IDX_W       = 20;
    localparam int DIST_W      = 40;
    localparam int SQ_W        = 32;
    localparam int VLEN_W      = 9;
    localparam int KCNT_W      = 7;
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_INDEX_W = 1;
    localparam int OUT_TDATA_W = 64;

    // opcode carried in tuser
    localparam logic OP_QUERY    = 1'b0;
    localparam logic OP_DATABASE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_VECTOR_LENGTH = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEEP_COUNT    = 1'b1;

    localparam logic [VLEN_W-1:0] VLEN_RESET = 9'd128;
    localparam logic [KCNT_W-1:0] KCNT_RESET = 7'd10;

    localparam logic [DIST_W-1:0] DIST_SAT = {DIST_W{1'b1}};

    typedef struct packed {
        logic valid;
        logic db;
        logic last;
        logic eos;
    } stage_ctl_t;

    typedef struct packed {
        logic              valid;
        logic              offer;
        logic              eos;
        logic [IDX_W-1:0]  idx;
        logic [DIST_W-1:0] sqdist;
    } cand_t;

endpackage
`default_nettype wire

[rtl/l2tk_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// l2tk_front: element position tracking and query store
// Writes query elements, reads the matching query element for database
// elements and registers the item with its control flags.
// ----------------------------------------------------------------------------
module l2tk_front #(
    parameter int MAX_LENGTH = 256,
    parameter int PW         = 8,
    parameter int LCMP_W     = 14
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            accept,
    input  wire                            adv,
    input  wire                            opcode,
    input  wire  [l2tk_pkg::ELEM_W-1:0]    element_value,
    input  wire                            end_of_stream,
    input  wire  [LCMP_W-1:0]              eff_length,
    output l2tk_pkg::stage_ctl_t           s1_ctl,
    output logic [l2tk_pkg::ELEM_W-1:0]    s1_elem,
    output logic [l2tk_pkg::ELEM_W-1:0]    s1_query
);
    import l2tk_pkg::*;

    logic [ELEM_W-1:0] query_mem [MAX_LENGTH];
    logic [PW-1:0]     pos_reg;
    logic [PW-1:0]     pos_next;
    logic              last_elem;
    stage_ctl_t        ctl_reg;
    stage_ctl_t        ctl_next;
    logic [ELEM_W-1:0] elem_reg;
    logic [ELEM_W-1:0] query_rd_reg;

    assign last_elem = (LCMP_W'(pos_reg) + LCMP_W'(1)) >= eff_length;

    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            if (end_of_stream || last_elem)
                pos_next = '0;
            else
                pos_next = pos_reg + PW'(1);
        end
    end

    always_comb
    begin
        ctl_next.valid = accept;
        ctl_next.db    = (opcode == OP_DATABASE);
        ctl_next.last  = last_elem;
        ctl_next.eos   = end_of_stream;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            ctl_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            if (adv)
                ctl_reg <= ctl_next;
        end
    end

    // query store: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (accept && opcode == OP_QUERY)
            query_mem[pos_reg] <= element_value;
        if (adv)
        begin
            query_rd_reg <= query_mem[pos_reg];
            elem_reg     <= element_value;
        end
    end

    assign s1_ctl   = ctl_reg;
    assign s1_elem  = elem_reg;
    assign s1_query = query_rd_reg;

endmodule
`default_nettype wire

[rtl/l2tk_dist_acc.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// l2tk_dist_acc: squared difference and running distance
// Registers the squared difference, then accumulates with saturation and
// hands a finished vector to the sorted list with its arrival index.
// ----------------------------------------------------------------------------
module l2tk_dist_acc #(
    parameter int MAX_VECTORS = 1048576,
    parameter int CW          = 21
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            adv,
    input  l2tk_pkg::stage_ctl_t           s1_ctl,
    input  wire  [l2tk_pkg::ELEM_W-1:0]    s1_elem,
    input  wire  [l2tk_pkg::ELEM_W-1:0]    s1_query,
    output l2tk_pkg::cand_t                cand
);
    import l2tk_pkg::*;

    logic signed [ELEM_W:0] diff;
    logic signed [ELEM_W:0] diff_neg;
    logic [ELEM_W-1:0]      diff_abs;
    logic [SQ_W-1:0]        sq;
    logic [SQ_W-1:0]        sq_reg;
    stage_ctl_t             s2_ctl_reg;
    logic [DIST_W:0]        acc_sum;
    logic [DIST_W-1:0]      acc_sat;
    logic [DIST_W-1:0]      acc_reg;
    logic [DIST_W-1:0]      acc_next;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic                   has_room;
    cand_t                  cand_reg;
    cand_t                  cand_next;

    assign diff     = $signed({s1_query[ELEM_W-1], s1_query})
                    - $signed({s1_elem[ELEM_W-1], s1_elem});
    assign diff_neg = -diff;
    assign diff_abs = diff[ELEM_W] ? diff_neg[ELEM_W-1:0] : diff[ELEM_W-1:0];
    assign sq       = diff_abs * diff_abs;

    assign acc_sum  = {1'b0, acc_reg} + (DIST_W+1)'(sq_reg);
    assign acc_sat  = acc_sum[DIST_W] ? DIST_SAT : acc_sum[DIST_W-1:0];
    assign has_room = count_reg < CW'(MAX_VECTORS);

    always_comb
    begin
        acc_next         = acc_reg;
        count_next       = count_reg;
        cand_next.valid  = s2_ctl_reg.valid;
        cand_next.offer  = 1'b0;
        cand_next.eos    = s2_ctl_reg.valid && s2_ctl_reg.eos;
        cand_next.idx    = IDX_W'(count_reg);
        cand_next.sqdist = acc_sat;
        if (s2_ctl_reg.valid)
        begin
            if (!s2_ctl_reg.db)
                acc_next = '0;
            else if (s2_ctl_reg.last)
            begin
                acc_next = '0;
                if (has_room)
                begin
                    cand_next.offer = 1'b1;
                    count_next      = count_reg + CW'(1);
                end
            end
            else
                acc_next = acc_sat;
            if (s2_ctl_reg.eos)
            begin
                acc_next   = '0;
                count_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_ctl_reg <= '0;
            acc_reg    <= '0;
            count_reg  <= '0;
            cand_reg   <= '0;
        end
        else if (adv)
        begin
            s2_ctl_reg <= s1_ctl;
            acc_reg    <= acc_next;
            count_reg  <= count_next;
            cand_reg   <= cand_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            sq_reg <= sq;
    end

    assign cand = cand_reg;

endmodule
`default_nettype wire

[rtl/l2tk_sorted_list.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// l2tk_sorted_list: kept list of the nearest vectors
// Each entry compares itself with the candidate in parallel; the entries
// behind the insertion point shift down by one. At end of stream the
// updated list goes to the result buffer and the list empties.
// ----------------------------------------------------------------------------
module l2tk_sorted_list #(
    parameter int MAX_KEEP = 64,
    parameter int KEEP_W   = 7
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            step,
    input  l2tk_pkg::cand_t                cand,
    input  wire  [KEEP_W-1:0]              keep,
    output logic                           load_valid,
    output logic [KEEP_W-1:0]              load_count,
    output logic [l2tk_pkg::IDX_W-1:0]     load_idx [MAX_KEEP],
    output logic [l2tk_pkg::DIST_W-1:0]    load_dist [MAX_KEEP]
);
    import l2tk_pkg::*;

    logic [IDX_W-1:0]    idx_reg  [MAX_KEEP];
    logic [DIST_W-1:0]   dist_reg [MAX_KEEP];
    logic [IDX_W-1:0]    idx_next  [MAX_KEEP];
    logic [DIST_W-1:0]   dist_next [MAX_KEEP];
    logic [KEEP_W-1:0]   fill_reg;
    logic [KEEP_W-1:0]   fill_eff;
    logic [KEEP_W-1:0]   fill_new;
    logic [MAX_KEEP-1:0] behind;
    logic [MAX_KEEP-1:0] in_keep;
    logic                take;

    // a shrunken keep count cuts the list to its best entries
    assign fill_eff = (fill_reg > keep) ? keep : fill_reg;

    always_comb
    begin
        for (int i = 0; i < MAX_KEEP; i++)
        begin
            behind[i]  = (KEEP_W'(i) >= fill_eff) || (dist_reg[i] > cand.sqdist);
            in_keep[i] = KEEP_W'(i) < keep;
        end
    end

    assign take = cand.offer && (|(behind & in_keep));

    always_comb
    begin
        for (int i = 0; i < MAX_KEEP; i++)
        begin
            idx_next[i]  = idx_reg[i];
            dist_next[i] = dist_reg[i];
            if (take && behind[i])
            begin
                if (i == 0)
                begin
                    idx_next[i]  = cand.idx;
                    dist_next[i] = cand.sqdist;
                end
                else if (!behind[i-1])
                begin
                    idx_next[i]  = cand.idx;
                    dist_next[i] = cand.sqdist;
                end
                else
                begin
                    idx_next[i]  = idx_reg[i-1];
                    dist_next[i] = dist_reg[i-1];
                end
            end
        end
    end

    always_comb
    begin
        fill_new = fill_eff;
        if (take && fill_eff != keep)
            fill_new = fill_eff + KEEP_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else if (step)
            fill_reg <= cand.eos ? '0 : fill_new;
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            idx_reg  <= idx_next;
            dist_reg <= dist_next;
        end
    end

    assign load_valid = step && cand.eos;
    assign load_count = fill_new;
    assign load_idx   = idx_next;
    assign load_dist  = dist_next;

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= KEEP_W'(MAX_KEEP))
        else $error("kept list fill beyond capacity");

    a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && cand.eos |=> fill_reg == '0)
        else $error("kept list not cleared after end of stream");

    for (genvar g = 0; g + 1 < MAX_KEEP; g++)
    begin : g_order
        a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
            KEEP_W'(g + 1) < fill_reg |-> dist_reg[g] <= dist_reg[g+1])
            else $error("kept list out of order");
    end
`endif

endmodule
`default_nettype wire

[rtl/l2tk_result_buf.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// l2tk_result_buf: result shift buffer
// Takes a whole sorted list in parallel and shifts it out one transfer
// at a time, head entry first.
// ----------------------------------------------------------------------------
module l2tk_result_buf #(
    parameter int MAX_KEEP = 64,
    parameter int KEEP_W   = 7
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 load_valid,
    input  wire  [KEEP_W-1:0]                   load_count,
    input  wire  [l2tk_pkg::IDX_W-1:0]          load_idx [MAX_KEEP],
    input  wire  [l2tk_pkg::DIST_W-1:0]         load_dist [MAX_KEEP],
    output logic                                empty,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // [19:0] vector_index, [59:20] squared_distance, [63:60] zero
    output logic [l2tk_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tlast
);
    import l2tk_pkg::*;

    localparam int PAD_W = OUT_TDATA_W - IDX_W - DIST_W;

    logic [IDX_W-1:0]  idx_reg  [MAX_KEEP];
    logic [DIST_W-1:0] dist_reg [MAX_KEEP];
    logic [KEEP_W-1:0] count_reg;
    logic              xfer;

    assign empty = (count_reg == '0);
    assign xfer  = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (load_valid)
            count_reg <= load_count;
        else if (xfer)
            count_reg <= count_reg - KEEP_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (load_valid)
        begin
            idx_reg  <= load_idx;
            dist_reg <= load_dist;
        end
        else if (xfer)
        begin
            for (int i = 0; i + 1 < MAX_KEEP; i++)
            begin
                idx_reg[i]  <= idx_reg[i+1];
                dist_reg[i] <= dist_reg[i+1];
            end
        end
    end

    assign m_axis_tvalid = !empty;
    assign m_axis_tdata  = {PAD_W'(0), dist_reg[0], idx_reg[0]};
    assign m_axis_tlast  = (count_reg == KEEP_W'(1));

`ifndef NO_ASSERTIONS
    a_load_empty: assert property (@(posedge clk) disable iff (!rst_n)
        load_valid |-> count_reg == '0)
        else $error("result buffer loaded while draining");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= KEEP_W'(MAX_KEEP))
        else $error("result count beyond capacity");

    a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
        xfer && count_reg == KEEP_W'(1) |=> count_reg == '0)
        else $error("result buffer not empty after final transfer");
`endif

endmodule
`default_nettype wire

[rtl/l2_top_k_nearest_search.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// l2_top_k_nearest_search: brute-force k-nearest search, squared L2 distance
// Path: an element passes the front, squared-difference and candidate
//   registers before the kept list; end of stream then loads the buffer.
// Throughput: one element per cycle, set by the single-port query store and
//   one multiplier; input stalls only while a finished list waits for the
//   previous one to drain. Results leave at one per cycle while tready is high.
// Reset clears all control state at once.
// ----------------------------------------------------------------------------
module l2_top_k_nearest_search #(
    parameter int MAX_LENGTH  = 256,
    parameter int MAX_KEEP    = 64,
    parameter int MAX_VECTORS = 1048576
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_we,
    input  wire  [l2tk_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire  [l2tk_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // [15:0] element_value
    input  wire  [l2tk_pkg::ELEM_W-1:0]         s_axis_tdata,
    // [0] opcode
    input  wire                                 s_axis_tuser,
    input  wire                                 s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // [19:0] vector_index, [59:20] squared_distance, [63:60] zero
    output logic [l2tk_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tlast
);
    import l2tk_pkg::*;

    localparam int PW     = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int LCMP_W = ((VLEN_W > $clog2(MAX_LENGTH + 1))
                            ? VLEN_W : $clog2(MAX_LENGTH + 1)) + 1;
    localparam int KEEP_W = $clog2(MAX_KEEP + 1);
    localparam int CW     = $clog2(MAX_VECTORS + 1);

    logic [VLEN_W-1:0] vlen_reg;
    logic [KCNT_W-1:0] kcnt_reg;
    logic [LCMP_W-1:0] vlen_ext;
    logic [LCMP_W-1:0] eff_length;
    logic [KCNT_W-1:0] keep_clamped;
    logic [KEEP_W-1:0] eff_keep;
    logic              accept;
    logic              adv;
    logic              stall;
    logic              buf_empty;
    stage_ctl_t        s1_ctl;
    logic [ELEM_W-1:0] s1_elem;
    logic [ELEM_W-1:0] s1_query;
    cand_t             cand;
    logic              load_valid;
    logic [KEEP_W-1:0] load_count;
    logic [IDX_W-1:0]  load_idx  [MAX_KEEP];
    logic [DIST_W-1:0] load_dist [MAX_KEEP];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vlen_reg <= VLEN_RESET;
            kcnt_reg <= KCNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_VECTOR_LENGTH: vlen_reg <= cfg_data;
                REG_KEEP_COUNT:    kcnt_reg <= cfg_data[KCNT_W-1:0];
                default:           ;
            endcase
        end
    end

    // zero acts as one, oversize clamps to capacity
    assign vlen_ext   = LCMP_W'(vlen_reg);
    assign eff_length = (vlen_reg == '0) ? LCMP_W'(1)
                      : (vlen_ext > LCMP_W'(MAX_LENGTH)) ? LCMP_W'(MAX_LENGTH)
                      : vlen_ext;
    assign keep_clamped = (kcnt_reg == '0) ? KCNT_W'(1)
                        : (kcnt_reg > KCNT_W'(MAX_KEEP)) ? KCNT_W'(MAX_KEEP)
                        : kcnt_reg;
    assign eff_keep = KEEP_W'(keep_clamped);

    // whole pipeline holds while a finished list waits for the buffer
    assign stall         = cand.valid && cand.eos && !buf_empty;
    assign adv           = !stall;
    assign s_axis_tready = adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    l2tk_front #(
        .MAX_LENGTH (MAX_LENGTH),
        .PW         (PW),
        .LCMP_W     (LCMP_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .adv           (adv),
        .opcode        (s_axis_tuser),
        .element_value (s_axis_tdata),
        .end_of_stream (s_axis_tlast),
        .eff_length    (eff_length),
        .s1_ctl        (s1_ctl),
        .s1_elem       (s1_elem),
        .s1_query      (s1_query)
    );

    l2tk_dist_acc #(
        .MAX_VECTORS (MAX_VECTORS),
        .CW          (CW)
    ) u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .s1_ctl   (s1_ctl),
        .s1_elem  (s1_elem),
        .s1_query (s1_query),
        .cand     (cand)
    );

    l2tk_sorted_list #(
        .MAX_KEEP (MAX_KEEP),
        .KEEP_W   (KEEP_W)
    ) u_list (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (cand.valid && adv),
        .cand       (cand),
        .keep       (eff_keep),
        .load_valid (load_valid),
        .load_count (load_count),
        .load_idx   (load_idx),
        .load_dist  (load_dist)
    );

    l2tk_result_buf #(
        .MAX_KEEP (MAX_KEEP),
        .KEEP_W   (KEEP_W)
    ) u_buf (
        .clk           (clk),
        .rst_n         (rst_n),
        .load_valid    (load_valid),
        .load_count    (load_count),
        .load_idx      (load_idx),
        .load_dist     (load_dist),
        .empty         (buf_empty),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
`default_nettype wire
